FILE: sv/fst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_pkg: shared definitions for the format string tokeniser
// Token kinds, register indices, character constants and the token record.
// ----------------------------------------------------------------------------
package fst_pkg;

  // Default width of the internal run, width and precision counters.
  localparam int COUNT_BITS_DEF = 16;

  // Entries in the result queue.
  localparam int QUEUE_DEPTH = 4;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_D  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_F  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_S  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_P  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_X  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_SPECIAL = 8'd37;
  localparam logic [7:0] RST_SPEC_D  = 8'd100;
  localparam logic [7:0] RST_SPEC_F  = 8'd102;
  localparam logic [7:0] RST_SPEC_S  = 8'd115;
  localparam logic [7:0] RST_SPEC_P  = 8'd112;
  localparam logic [7:0] RST_SPEC_X  = 8'd120;

  // Fixed characters recognised inside a spec.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Token kinds.
  typedef enum logic [3:0] {
    KIND_TEXT    = 4'd0,
    KIND_LITERAL = 4'd1,
    KIND_D       = 4'd2,
    KIND_F       = 4'd3,
    KIND_S       = 4'd4,
    KIND_P       = 4'd5,
    KIND_X       = 4'd6,
    KIND_ERROR   = 4'd7,
    KIND_END     = 4'd8
  } kind_t;

  // Flags gathered while a spec is open.
  typedef struct packed {
    logic err;
    logic flag_seen;
    logic left;
    logic dot;
    logic wid;
    logic prec;
  } spec_flags_t;

  // One result beat.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] token_length;
    logic [15:0] field_width;
    logic [15:0] precision_value;
    logic        width_given;
    logic        precision_given;
    logic        left_align;
    logic        last;
  } token_t;

endpackage

FILE: sv/format_spec_tokenizer.sv
// A result beat is written into the result queue on the cycle after the input beat that causes it.
// Throughput: one input byte per cycle while the result queue holds two entries or fewer; a
// byte that yields two tokens (a text run or an open spec closed by the end byte) pushes both,
// and the single result port drains them from the four-entry result queue.
// Reset (synchronous, rst_n low): registers return to their default characters,
// the tokeniser returns to a text run with all counters and flags clear, queue empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// format_spec_tokenizer: format string tokeniser
// Splits a zero-terminated format string, one byte per beat, into text runs
// and conversion specs with their flags, width and precision.
// ----------------------------------------------------------------------------
module format_spec_tokenizer #(
  parameter int COUNT_BITS = fst_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input stream: in_tdata = in_byte[7:0].
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,
  // Result stream: out_tuser = kind[3:0].
  // out_tdata = token_length[15:0], field_width[31:16], precision_value[47:32],
  // width_given[48], precision_given[49], left_align[50], zero pad[55:51].
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [55:0]                out_tdata,
  output logic [3:0]                 out_tuser,
  output logic                       out_tlast,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_data
);

  import fst_pkg::*;

  localparam int CB = COUNT_BITS;
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers.
  logic [7:0] special_r, spec_d_r, spec_f_r, spec_s_r, spec_p_r, spec_x_r;

  // Tokeniser state.
  logic          in_spec_r, in_spec_nxt;
  logic [CB-1:0] run_r, run_nxt;
  logic [CB-1:0] wacc_r, wacc_nxt;
  logic [CB-1:0] pacc_r, pacc_nxt;
  spec_flags_t   flags_r, flags_nxt;

  // Result queue.
  token_t           queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic       in_fire, out_fire;
  logic [1:0] n_res;
  token_t     res0, res1;

  // Saturating helpers on the counter width.
  function automatic logic [15:0] sat16(input logic [CB-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return (ext > 32'd65535) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == CNT_MAX) ? v : v + CB'(1);
  endfunction

  function automatic logic [CB-1:0] sat_digit(input logic [CB-1:0] v, input logic [3:0] d);
    logic [CB+4:0] r;
    r = (CB+5)'({v, 3'b000}) + (CB+5)'({v, 1'b0}) + (CB+5)'(d);
    return (r > (CB+5)'(CNT_MAX)) ? CNT_MAX : r[CB-1:0];
  endfunction

  function automatic token_t mk_tok(input kind_t k, input logic [CB-1:0] len,
                                    input logic spec, input logic [CB-1:0] w,
                                    input logic [CB-1:0] p, input spec_flags_t f);
    token_t t;
    t.kind            = k;
    t.token_length    = sat16(len);
    t.field_width     = spec ? sat16(w) : 16'd0;
    t.precision_value = spec ? sat16(p) : 16'd0;
    t.width_given     = spec & f.wid;
    t.precision_given = spec & f.prec;
    t.left_align      = spec & f.left;
    t.last            = 1'b0;
    return t;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_tready = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_fire  = out_tvalid && out_tready;

  // Configuration writes; indices beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      special_r <= RST_SPECIAL;
      spec_d_r  <= RST_SPEC_D;
      spec_f_r  <= RST_SPEC_F;
      spec_s_r  <= RST_SPEC_S;
      spec_p_r  <= RST_SPEC_P;
      spec_x_r  <= RST_SPEC_X;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SPECIAL: special_r <= cfg_data;
        CFG_SPEC_D:  spec_d_r  <= cfg_data;
        CFG_SPEC_F:  spec_f_r  <= cfg_data;
        CFG_SPEC_S:  spec_s_r  <= cfg_data;
        CFG_SPEC_P:  spec_p_r  <= cfg_data;
        CFG_SPEC_X:  spec_x_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-byte decode: next state and up to two tokens.
  always_comb begin
    logic [7:0]    b;
    logic          close;
    kind_t         k;
    logic [CB-1:0] run_inc;
    b           = in_tdata;
    close       = 1'b0;
    k           = KIND_ERROR;
    run_inc     = sat_inc(run_r);
    in_spec_nxt = in_spec_r;
    run_nxt     = run_r;
    wacc_nxt    = wacc_r;
    pacc_nxt    = pacc_r;
    flags_nxt   = flags_r;
    n_res       = 2'd0;
    res0        = mk_tok(KIND_END, '0, 1'b0, '0, '0, '0);
    res1        = res0;
    if (!in_spec_r) begin
      // Text run.
      priority if (b == CH_NUL) begin
        if (run_r != '0) begin
          res0  = mk_tok(KIND_TEXT, run_r, 1'b0, '0, '0, '0);
          n_res = 2'd2;
        end else begin
          n_res = 2'd1;
        end
        in_spec_nxt = 1'b0;
        run_nxt     = '0;
        wacc_nxt    = '0;
        pacc_nxt    = '0;
        flags_nxt   = '0;
      end else if (b == special_r) begin
        if (run_r != '0) begin
          res0  = mk_tok(KIND_TEXT, run_r, 1'b0, '0, '0, '0);
          n_res = 2'd1;
        end
        in_spec_nxt = 1'b1;
        run_nxt     = CB'(1);
        wacc_nxt    = '0;
        pacc_nxt    = '0;
        flags_nxt   = '0;
      end else begin
        run_nxt = run_inc;
      end
    end else if (b == CH_NUL) begin
      // Unterminated spec: error token with the bytes so far, then the end marker.
      res0        = mk_tok(KIND_ERROR, run_r, 1'b1, wacc_r, pacc_r, flags_r);
      n_res       = 2'd2;
      in_spec_nxt = 1'b0;
      run_nxt     = '0;
      wacc_nxt    = '0;
      pacc_nxt    = '0;
      flags_nxt   = '0;
    end else begin
      // Open spec: gather flags, width and precision, or close.
      priority if (b == special_r) begin
        close = 1'b1;
        k     = (run_r == CB'(1) && !flags_r.err) ? KIND_LITERAL : KIND_ERROR;
      end else if (b == CH_MINUS || b == CH_PLUS) begin
        if (flags_r.flag_seen) flags_nxt.err = 1'b1;
        if (b == CH_MINUS) flags_nxt.left = 1'b1;
        flags_nxt.flag_seen = 1'b1;
      end else if (b >= CH_ZERO && b <= CH_NINE) begin
        if (!flags_r.dot) begin
          wacc_nxt      = sat_digit(wacc_r, b[3:0]);
          flags_nxt.wid = 1'b1;
        end else begin
          pacc_nxt       = sat_digit(pacc_r, b[3:0]);
          flags_nxt.prec = 1'b1;
        end
      end else if (b == CH_DOT) begin
        if (flags_r.dot) flags_nxt.err = 1'b1;
        flags_nxt.dot = 1'b1;
      end else if (b == spec_d_r) begin
        close = 1'b1;
        k     = KIND_D;
      end else if (b == spec_f_r) begin
        close = 1'b1;
        k     = KIND_F;
      end else if (b == spec_s_r) begin
        close = 1'b1;
        k     = KIND_S;
      end else if (b == spec_p_r) begin
        close = 1'b1;
        k     = KIND_P;
      end else if (b == spec_x_r) begin
        close = 1'b1;
        k     = KIND_X;
      end else begin
        close = 1'b0;
      end
      run_nxt = run_inc;
      if (close) begin
        if (flags_nxt.err) k = KIND_ERROR;
        res0        = mk_tok(k, run_inc, 1'b1, wacc_nxt, pacc_nxt, flags_nxt);
        n_res       = 2'd1;
        in_spec_nxt = 1'b0;
        run_nxt     = '0;
        wacc_nxt    = '0;
        pacc_nxt    = '0;
        flags_nxt   = '0;
      end
    end
    // Mark the final token caused by this byte.
    if (n_res == 2'd1) res0.last = 1'b1;
    res1.last = 1'b1;
  end

  // Tokeniser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_spec_r <= 1'b0;
      run_r     <= '0;
      wacc_r    <= '0;
      pacc_r    <= '0;
      flags_r   <= '0;
    end else if (in_fire) begin
      in_spec_r <= in_spec_nxt;
      run_r     <= run_nxt;
      wacc_r    <= wacc_nxt;
      pacc_r    <= pacc_nxt;
      flags_r   <= flags_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
      if (n_res == 2'd2) queue_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      if (out_fire) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + CNT_W'(in_fire ? n_res : 2'd0) - CNT_W'(out_fire);
    end
  end

  // Output beat from the head of the queue.
  token_t head;
  assign head      = queue_r[rd_ptr_r];
  assign out_tdata = {5'b00000, head.left_align, head.precision_given, head.width_given,
                      head.precision_value, head.field_width, head.token_length};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  // The queue never overfills.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // An accepted end byte always pushes the end marker and leaves the tokeniser clear.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tdata == CH_NUL) |=>
      (!in_spec_r && run_r == '0 && flags_r == '0 && count_r != '0))
    else $error("end byte did not clear state");

  // Inside a spec the byte count is never zero.
  a_spec_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_spec_r |-> (run_r != '0))
    else $error("open spec with zero length");

  // A spec opener from text moves into a spec with length one.
  a_open_spec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_spec_r && in_tdata != CH_NUL && in_tdata == special_r) |=>
      (in_spec_r && run_r == CB'(1)))
    else $error("spec opener not taken");

endmodule
